[rtl/cvr_pkg.sv]
// ----------------------------------------------------------------------------
// cvr_pkg
// Shared types, constants and constant-table functions for the CORDIC unit.
// ----------------------------------------------------------------------------
package cvr_pkg;

	localparam int DATA_W         = 32;
	localparam int CVR_ITERATIONS = 16;
	localparam int CVR_FRAC_BITS  = 16;

	// From this step on, atan(2^-i) lies a hair below 2^-i for every
	// supported fraction width, so the truncated entry is 2^(F-i) - 1.
	localparam int EXACT_STEP = 10;

	// Gain 0.607252935 as a decimal fraction.
	localparam longint unsigned GAIN_NUM = 64'd607252935;
	localparam longint unsigned GAIN_DEN = 64'd1000000000;

	// Mode codes carried in the command field.
	localparam logic CMD_ROTATE = 1'b0;
	localparam logic CMD_VECTOR = 1'b1;

	typedef struct packed {
		logic                     command;
		logic signed [DATA_W-1:0] angle_in;
		logic signed [DATA_W-1:0] y_in;
		logic signed [DATA_W-1:0] x_in;
	} cvr_in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] x_result;
		logic signed [DATA_W-1:0] y_result;
		logic signed [DATA_W-1:0] z_result;
	} cvr_out_t;

	// State of one item as it moves down the pipeline.
	typedef struct packed {
		logic              vld;
		logic              vect;
		logic [DATA_W-1:0] x;
		logic [DATA_W-1:0] y;
		logic [DATA_W-1:0] z;
	} cvr_vec_t;

	// floor(atan(2^-step) * 2^frac)
	function automatic logic [DATA_W-1:0] cvr_atan(input int step, input int frac);
		real              ang;
		longint unsigned  v;
		if (step >= EXACT_STEP) begin
			if (frac >= step)
				v = (64'd1 << (frac - step)) - 64'd1;
			else
				v = 64'd0;
		end else begin
			ang = $atan(2.0 ** (-step));
			v   = longint'($floor(ang * (2.0 ** frac)));
		end
		return v[DATA_W-1:0];
	endfunction

	// floor(0.607252935 * 2^frac)
	function automatic logic [DATA_W-1:0] cvr_gain(input int frac);
		longint unsigned p;
		p = (GAIN_NUM << frac) / GAIN_DEN;
		return p[DATA_W-1:0];
	endfunction

endpackage

[rtl/cordic_rotate_vector_unit.sv]
// The path from the start edge to the done strobe runs through one input register,
//   then one register per micro-rotation.
// Throughput: one item per cycle; busy is always low and the pipeline never stalls.
// Reset: arst_n clears only the valid bits, so no done strobe follows reset
//   until a new item is started; data registers are not reset.
// The receiver cannot stall: each result shows for one cycle with done high.
// ----------------------------------------------------------------------------
// cordic_rotate_vector_unit
// Circular CORDIC, rotation and vectoring modes, fully pipelined.
// ----------------------------------------------------------------------------
module cordic_rotate_vector_unit import cvr_pkg::*; #(
	parameter int ITERATIONS = CVR_ITERATIONS,
	parameter int FRAC_BITS  = CVR_FRAC_BITS
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  cvr_in_t  item,
	output logic     done,
	output cvr_out_t result
);

	// Pipeline bus: entry 0 is the input register, entry k the output of step k-1.
	cvr_vec_t stage_bus [0:ITERATIONS];

	// Every stage advances each cycle, so an item is taken whenever start is high.
	assign busy = 1'b0;

	// Input register: mode select and starting vector.
	cvr_init #(
		.FRAC_BITS(FRAC_BITS)
	) u_init (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (start),
		.item  (item),
		.vec_s0(stage_bus[0])
	);

	// One register stage per micro-rotation, each with its own shift amount
	// and atan constant.
	for (genvar k = 0; k < ITERATIONS; k++) begin : g_step
		cvr_stage #(
			.STEP     (k),
			.FRAC_BITS(FRAC_BITS)
		) u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.vec_in (stage_bus[k]),
			.vec_out(stage_bus[k+1])
		);
	end

	// Results come straight off the last stage register.
	assign done            = stage_bus[ITERATIONS].vld;
	assign result.x_result = stage_bus[ITERATIONS].x;
	assign result.y_result = stage_bus[ITERATIONS].y;
	assign result.z_result = stage_bus[ITERATIONS].z;

`ifndef SYNTHESIS
	// Every started item comes out after the fixed latency.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##(ITERATIONS + 1) done)
		else $error("started item did not complete on time");

	// No result without a matching start.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, ITERATIONS + 1))
		else $error("result without a started item");

	// Mode bit travels unchanged from input register to output.
	a_mode_kept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (stage_bus[ITERATIONS].vect == $past(stage_bus[0].vect, ITERATIONS)))
		else $error("mode bit corrupted in pipeline");
`endif

endmodule

[rtl/cvr_init.sv]
// ----------------------------------------------------------------------------
// cvr_init
// Input register: loads the starting x, y, z for the selected mode.
// ----------------------------------------------------------------------------
module cvr_init import cvr_pkg::*; #(
	parameter int FRAC_BITS = CVR_FRAC_BITS
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     load,
	input  cvr_in_t  item,
	output cvr_vec_t vec_s0
);

	localparam logic [DATA_W-1:0] GAIN = cvr_gain(FRAC_BITS);

	cvr_vec_t          nxt;
	logic              vld_s0;
	logic              vect_s0;
	logic [DATA_W-1:0] x_s0;
	logic [DATA_W-1:0] y_s0;
	logic [DATA_W-1:0] z_s0;

	always_comb begin
		nxt      = '0;
		nxt.vld  = load;
		nxt.vect = (item.command == CMD_VECTOR);
		if (item.command == CMD_VECTOR) begin
			nxt.x = item.x_in;
			nxt.y = item.y_in;
			nxt.z = '0;
		end else begin
			nxt.x = GAIN;
			nxt.y = '0;
			nxt.z = item.angle_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else begin
			vld_s0 <= nxt.vld;
		end
	end

	always_ff @(posedge clk) begin
		vect_s0 <= nxt.vect;
		x_s0    <= nxt.x;
		y_s0    <= nxt.y;
		z_s0    <= nxt.z;
	end

	assign vec_s0 = '{vld: vld_s0, vect: vect_s0, x: x_s0, y: y_s0, z: z_s0};

endmodule

[rtl/cvr_stage.sv]
// ----------------------------------------------------------------------------
// cvr_stage
// One registered micro-rotation: shift by the step index, add/sub, atan table.
// ----------------------------------------------------------------------------
module cvr_stage import cvr_pkg::*; #(
	parameter int STEP      = 0,
	parameter int FRAC_BITS = CVR_FRAC_BITS
) (
	input  logic     clk,
	input  logic     arst_n,
	input  cvr_vec_t vec_in,
	output cvr_vec_t vec_out
);

	localparam logic [DATA_W-1:0] ATAN = cvr_atan(STEP, FRAC_BITS);

	logic [DATA_W-1:0] dx;
	logic [DATA_W-1:0] dy;
	logic              sub;

	// Stage registers (_sn: stage STEP + 1).
	logic              vld_sn;
	logic              vect_sn;
	logic [DATA_W-1:0] x_sn;
	logic [DATA_W-1:0] y_sn;
	logic [DATA_W-1:0] z_sn;

	// Rotation steers on z >= 0, vectoring on y < 0 (zero counts as non-negative).
	assign sub = vec_in.vect ? vec_in.y[DATA_W-1] : ~vec_in.z[DATA_W-1];
	assign dx  = $signed(vec_in.y) >>> STEP;
	assign dy  = $signed(vec_in.x) >>> STEP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sn <= 1'b0;
		end else begin
			vld_sn <= vec_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		vect_sn <= vec_in.vect;
		if (sub) begin
			x_sn <= vec_in.x - dx;
			y_sn <= vec_in.y + dy;
			z_sn <= vec_in.z - ATAN;
		end else begin
			x_sn <= vec_in.x + dx;
			y_sn <= vec_in.y - dy;
			z_sn <= vec_in.z + ATAN;
		end
	end

	assign vec_out = '{vld: vld_sn, vect: vect_sn, x: x_sn, y: y_sn, z: z_sn};

endmodule
